/* rtl/core/jptp_pkg.sv */
// Package for the JSON Pointer token parser.
// Holds character constants, phase and result kind codes, and the stage structs.
// No dependencies.
`default_nettype none
package jptp_pkg;

    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] CNT_SAT = 2'd2;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_TOKEN = 3'b010,
        PH_ERROR = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_TOKEN = 3'd1,
        KIND_LAST  = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_mark;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] symbol_out;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   escape_wait;
    } status_t;

endpackage
`default_nettype wire

/* rtl/core/json_pointer_token_parser.sv */
// JSON Pointer token parser, top level: input register, decode core, result register.
// Result passes input and result registers; 1 item per cycle unless m_tready stalls.
// Rate is set by the single combinational decode step between the two stage registers.
// Reset (aresetn low, synchronous) empties both stages and returns the parser to start.
// Depends on jptp_pkg, jptp_in_stage, jptp_core, jptp_out_stage.
`default_nettype none
module json_pointer_token_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol
    input  wire logic       s_tlast,   // end_mark
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] symbol_out
    output logic [7:0]      m_tuser    // [2:0] kind, [7:3] zero
);
    import jptp_pkg::*;

    logic    advance;
    logic    item_valid;
    item_t   item;
    logic    fire;
    logic    res_valid;
    result_t res;
    status_t status;

    assign advance = !m_tvalid || m_tready;
    assign fire    = item_valid && advance;

    jptp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jptp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    jptp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_mark |=> status.phase == PH_START && !status.escape_wait)
        else $error("state not cleared after end item");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_mark |=> m_tvalid && m_tuser[2:0] != KIND_BYTE
                                  && m_tuser[2:0] != KIND_TOKEN)
        else $error("end item did not give a final result");

    a_nonbyte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] != KIND_BYTE |-> m_tdata == 8'h00)
        else $error("nonzero data on a non-byte result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

endmodule
`default_nettype wire

/* rtl/core/jptp_in_stage.sv */
// Input register of the JSON Pointer token parser.
// Takes one transfer per cycle while the next stage advances; uses jptp_pkg.
`default_nettype none
module jptp_in_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tlast,
    input  wire logic            advance,
    output logic                 item_valid,
    output jptp_pkg::item_t      item
);
    import jptp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.symbol   <= s_tdata;
            item_reg.end_mark <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* rtl/core/jptp_core.sv */
// Parser state and per-byte decode logic of the JSON Pointer token parser.
// Updates the token state on each processed item; uses jptp_pkg.
`default_nettype none
module jptp_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire jptp_pkg::item_t item,
    output logic                 res_valid,
    output jptp_pkg::result_t    res,
    output jptp_pkg::status_t    status
);
    import jptp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       fz_reg, fz_next;
    logic       dig_reg, dig_next;

    logic       token_bad;
    logic       take;
    logic [7:0] dec;

    assign token_bad = (cnt_reg == CNT_SAT) && fz_reg && dig_reg;

    always_comb begin
        phase_next     = phase_reg;
        esc_next       = esc_reg;
        cnt_next       = cnt_reg;
        fz_next        = fz_reg;
        dig_next       = dig_reg;
        res_valid      = 1'b0;
        res.kind       = KIND_BYTE;
        res.symbol_out = 8'h00;
        take           = 1'b0;
        dec            = item.symbol;

        if (fire) begin
            if (item.end_mark) begin
                res_valid = 1'b1;
                if (phase_reg == PH_START) begin
                    res.kind = KIND_EMPTY;
                end else if (phase_reg == PH_TOKEN && !esc_reg && !token_bad) begin
                    res.kind = KIND_LAST;
                end else begin
                    res.kind = KIND_ERROR;
                end
                phase_next = PH_START;
                esc_next   = 1'b0;
                cnt_next   = 2'd0;
                fz_next    = 1'b0;
                dig_next   = 1'b1;
            end else begin
                case (phase_reg)
                    PH_START: begin
                        if (item.symbol == CH_SLASH) begin
                            phase_next = PH_TOKEN;
                            esc_next   = 1'b0;
                            cnt_next   = 2'd0;
                            fz_next    = 1'b0;
                            dig_next   = 1'b1;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_TOKEN: begin
                        if (esc_reg) begin
                            esc_next = 1'b0;
                            if (item.symbol == CH_ZERO) begin
                                take = 1'b1;
                                dec  = CH_TILDE;
                            end else if (item.symbol == CH_ONE) begin
                                take = 1'b1;
                                dec  = CH_SLASH;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end else if (item.symbol == CH_TILDE) begin
                            esc_next = 1'b1;
                        end else if (item.symbol == CH_SLASH) begin
                            if (token_bad) begin
                                phase_next = PH_ERROR;
                            end else begin
                                esc_next  = 1'b0;
                                cnt_next  = 2'd0;
                                fz_next   = 1'b0;
                                dig_next  = 1'b1;
                                res_valid = 1'b1;
                                res.kind  = KIND_TOKEN;
                            end
                        end else begin
                            take = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                if (take) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_BYTE;
                    res.symbol_out = dec;
                    if (cnt_reg == 2'd0) begin
                        fz_next = (dec == CH_ZERO);
                    end
                    if (dec < CH_ZERO || dec > CH_NINE) begin
                        dig_next = 1'b0;
                    end
                    if (cnt_reg < CNT_SAT) begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            esc_reg   <= 1'b0;
            cnt_reg   <= 2'd0;
            fz_reg    <= 1'b0;
            dig_reg   <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            cnt_reg   <= cnt_next;
            fz_reg    <= fz_next;
            dig_reg   <= dig_next;
        end
    end

    assign status.phase       = phase_reg;
    assign status.escape_wait = esc_reg;

endmodule
`default_nettype wire

/* rtl/core/jptp_out_stage.sv */
// Result register of the JSON Pointer token parser.
// Holds one result transfer until taken; uses jptp_pkg.
`default_nettype none
module jptp_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic              res_valid,
    input  wire jptp_pkg::result_t res,
    output logic                   m_tvalid,
    output logic [7:0]             m_tdata,
    output logic [7:0]             m_tuser
);
    import jptp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.symbol_out;
    assign m_tuser  = {5'b00000, res_reg.kind};

endmodule
`default_nettype wire

/* dv/json_pointer_checker.sv */
// Result checker for json_pointer_token_parser: tracks the parse state from input transfers,
// predicts each result and compares it with the result channel in order.
// Depends on jptp_pkg.
`timescale 1ns / 100ps
module json_pointer_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [7:0] m_tuser,
    output int         pending,
    output int         fail_count
);
    import jptp_pkg::*;

    phase_t     ph;
    logic       esc_wait;
    logic [1:0] tok_len;
    logic       lead_zero;
    logic       num_only;

    result_t predicted_out[$];

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    task clear_token();
        esc_wait  = 1'b0;
        tok_len   = 2'd0;
        lead_zero = 1'b0;
        num_only  = 1'b1;
    endtask

    function bit token_bad();
        return tok_len >= CNT_SAT && lead_zero && num_only;
    endfunction

    task take_decoded(input logic [7:0] d, output bit has, output result_t res);
        if (tok_len == 2'd0)
            lead_zero = (d == CH_ZERO);
        if (d < CH_ZERO || d > CH_NINE)
            num_only = 1'b0;
        if (tok_len < CNT_SAT)
            tok_len = tok_len + 2'd1;
        has            = 1'b1;
        res.kind       = KIND_BYTE;
        res.symbol_out = d;
    endtask

    task parse_step(input logic [7:0] b, input logic fin, output bit has, output result_t res);
        has            = 1'b0;
        res.kind       = KIND_BYTE;
        res.symbol_out = 8'h00;
        if (fin) begin
            has = 1'b1;
            if (ph == PH_START)
                res.kind = KIND_EMPTY;
            else if (ph == PH_TOKEN && !esc_wait && !token_bad())
                res.kind = KIND_LAST;
            else
                res.kind = KIND_ERROR;
            ph = PH_START;
            clear_token();
        end else if (ph == PH_START) begin
            if (b == CH_SLASH) begin
                ph = PH_TOKEN;
                clear_token();
            end else begin
                ph = PH_ERROR;
            end
        end else if (ph == PH_TOKEN) begin
            if (esc_wait) begin
                esc_wait = 1'b0;
                if (b == CH_ZERO)
                    take_decoded(CH_TILDE, has, res);
                else if (b == CH_ONE)
                    take_decoded(CH_SLASH, has, res);
                else
                    ph = PH_ERROR;
            end else if (b == CH_TILDE) begin
                esc_wait = 1'b1;
            end else if (b == CH_SLASH) begin
                if (token_bad()) begin
                    ph = PH_ERROR;
                end else begin
                    clear_token();
                    has      = 1'b1;
                    res.kind = KIND_TOKEN;
                end
            end else begin
                take_decoded(b, has, res);
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t next;
        bit      got_one;
        if (!aresetn) begin
            ph = PH_START;
            clear_token();
            predicted_out.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_out.size() == 0) begin
                    $error("unexpected result transfer: kind %0d symbol_out 0x%02h",
                           m_tuser[2:0], m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_out.pop_front();
                    if (m_tuser[2:0] !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d",
                               want.kind, m_tuser[2:0]);
                        fail_count++;
                    end
                    if (m_tdata !== want.symbol_out) begin
                        $error("symbol_out mismatch: expected 0x%02h, actual 0x%02h",
                               want.symbol_out, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[7:3] !== 5'd0) begin
                        $error("tuser pad mismatch: expected 0x00, actual 0x%02h",
                               m_tuser[7:3]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_step(s_tdata, s_tlast, got_one, next);
                if (got_one)
                    predicted_out.push_back(next);
            end
        end
        pending = predicted_out.size();
    end

endmodule

/* dv/tb_json_pointer_token_parser.sv */
// Testbench top for json_pointer_token_parser: clock, reset, pointer string stimulus
// with random idling on both channels, and the final verdict.
// Depends on jptp_pkg, json_pointer_token_parser and json_pointer_checker.
`timescale 1ns / 100ps
module tb_json_pointer_token_parser;
    import jptp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 650;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [7:0] m_tuser;

    int pending;
    int fail_count;
    int items_sent = 0;
    int cycles     = 0;
    bit calm       = 1'b0;

    always #6 aclk = ~aclk;

    json_pointer_token_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    json_pointer_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("json_pointer_token_parser test failed");
            $finish;
        end
    end

    task automatic push_item(input logic [7:0] sym, input logic fin);
        if (!calm) begin
            while ($urandom_range(0, 99) < 27) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_pointer(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_item(txt[i], 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (pending != 0);
        @(posedge aclk);
    endtask

    // mostly well-formed pointers with random tokens, some noise and broken escapes
    task automatic send_random_pointer();
        logic [7:0] str[$];
        logic [7:0] b;
        int         sel;
        int         ntok;
        int         len;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            // empty pointer
        end else if (sel < 16) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                str.push_back(8'($urandom_range(0, 255)));
        end else begin
            str.push_back(CH_SLASH);
            ntok = $urandom_range(1, 4);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0)
                    str.push_back(CH_SLASH);
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0, 1: str.push_back(CH_ZERO);
                        2, 3: str.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        4: begin
                            str.push_back(CH_TILDE);
                            str.push_back(CH_ZERO);
                        end
                        5: begin
                            str.push_back(CH_TILDE);
                            str.push_back(CH_ONE);
                        end
                        6, 7: str.push_back(8'("a" + $urandom_range(0, 25)));
                        default: str.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            if ($urandom_range(0, 4) == 0)
                str.push_back(CH_SLASH);
            case ($urandom_range(0, 11))
                0: str.push_back(CH_TILDE);
                1: begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_ZERO || b == CH_ONE);
                    str.push_back(CH_TILDE);
                    str.push_back(b);
                    str.push_back("z");
                end
                2: begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_SLASH);
                    str[0] = b;
                end
                default: ;
            endcase
        end
        foreach (str[i])
            push_item(str[i], 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int base;
        int n_ptr;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pointer("");
        send_pointer("/");
        push_item(CH_SLASH, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        send_pointer("~0~1/");
        send_pointer("x/");
        send_pointer("/~");
        send_pointer("/~/");
        send_pointer("/01/");

        base  = items_sent;
        n_ptr = 0;
        while (items_sent < base + RANDOM_ITEMS) begin
            calm = (n_ptr >= 30 && n_ptr < 50);
            if (n_ptr == 55)
                wait_results_drained();
            send_random_pointer();
            n_ptr++;
        end
        calm = 1'b0;

        wait_results_drained();
        repeat (8) @(negedge aclk);
        if (fail_count == 0)
            $display("json_pointer_token_parser test passed");
        else
            $display("json_pointer_token_parser test failed");
        $finish;
    end

endmodule
